### hw/rtl/i2c_display_write_master_core_macros.svh
// Assertion macros shared by the write master checker.
`ifndef I2C_DISPLAY_WRITE_MASTER_CORE_MACROS_SVH
`define I2C_DISPLAY_WRITE_MASTER_CORE_MACROS_SVH

// Clocked assertion, disabled while reset is held.
`define I2CDW_ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Condition that must never be seen while out of reset.
`define I2CDW_ASSERT_NEVER(lbl, cond, msg) \
  `I2CDW_ASSERT_CLK(lbl, !(cond), msg)

`endif

### hw/rtl/i2cdw_pkg.sv
// Types and constants of the display write master.
`timescale 1ns / 1ps

package i2cdw_pkg;

  localparam int HalfPeriodW = 16;
  localparam int AddrW       = 8;
  localparam int CfgDataW    = 16;
  localparam int CfgIdxW     = 1;

  localparam logic [CfgIdxW-1:0] CFG_HALF_PERIOD = 1'b0;
  localparam logic [CfgIdxW-1:0] CFG_SLAVE_ADDR  = 1'b1;

  localparam logic [HalfPeriodW-1:0] HALF_PERIOD_RST = 16'd40;
  localparam logic [AddrW-1:0]       SLAVE_ADDR_RST  = 8'h78;

  localparam logic [2:0] ACT_TICK    = 3'd0;
  localparam logic [2:0] ACT_CMD     = 3'd1;
  localparam logic [2:0] ACT_DATA    = 3'd2;
  localparam logic [2:0] ACT_PROBE   = 3'd3;
  localparam logic [2:0] ACT_RECOVER = 3'd4;
  localparam logic [2:0] ACT_CHECK   = 3'd5;

  localparam logic [7:0] CTRL_CMD  = 8'h00;
  localparam logic [7:0] CTRL_DATA = 8'h40;

  localparam logic [3:0] RECOVER_PULSES = 4'd9;
  localparam logic [1:0] STUCK_SCL      = 2'b01;
  localparam logic [1:0] STUCK_SDA      = 2'b10;

  typedef struct packed {
    logic [2:0] action;
    logic [7:0] payload;
    logic       sda_in;
    logic       scl_in;
  } in_t;

  typedef struct packed {
    logic       scl_out;
    logic       sda_out;
    logic       busy_res;
    logic       done_res;
    logic [2:0] ack_bits;
    logic [1:0] bus_status;
    logic       rejected;
  } out_t;

  typedef struct packed {
    logic [HalfPeriodW-1:0] half_period;
    logic [AddrW-1:0]       slave_address;
  } cfg_t;

endpackage

### hw/rtl/i2c_display_write_master_core.sv
// Top level of the display write master: request/result registers and config.
`timescale 1ns / 1ps
// Open-drain I2C write master, one request per bus timing tick.
// Input channel: in_valid_i / in_stall_o carry in_req_i (action, payload and
// the sampled SDA/SCL levels). Every accepted request advances the sequencer
// by one tick; action selects command write, data write, probe, recovery or
// bus check, and requests arriving mid-sequence come back flagged rejected.
// Output channel: out_valid_o / out_stall_i carry out_res_o, one result per
// request: pin drives, busy, done, acknowledge bits and bus status.
// Each request passes the input register, then the result register, with a
// single sequencer update between them; one request per cycle is accepted
// unless the receiver stalls a valid result.
// When the receiver stalls, the result holds and the input register absorbs
// one more request before in_stall_o rises.
// Reset clears both valid flags, releases both lines and loads half_period 40
// and slave_address 0x78. Config writes via cfg_we_i / cfg_idx_i /
// cfg_wdata_i take effect at once and belong in idle periods only.
module i2c_display_write_master_core #(
  parameter int HOLD_BITS = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  i2cdw_pkg::in_t                      in_req_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output i2cdw_pkg::out_t                     out_res_o,
  input  logic                                cfg_we_i,
  input  logic [i2cdw_pkg::CfgIdxW-1:0]       cfg_idx_i,
  input  logic [i2cdw_pkg::CfgDataW-1:0]      cfg_wdata_i
);

  logic            in_valid_q, in_valid_d;
  i2cdw_pkg::in_t  in_q;
  logic            out_valid_q, out_valid_d;
  i2cdw_pkg::out_t out_q, res;
  i2cdw_pkg::cfg_t cfg_q;
  logic            take, adv, acc;

  assign take = !out_valid_q || !out_stall_i;
  assign adv  = in_valid_q && take;
  assign in_stall_o = in_valid_q && !take;
  assign acc  = in_valid_i && !in_stall_o;

  assign in_valid_d  = acc ? 1'b1 : (adv ? 1'b0 : in_valid_q);
  assign out_valid_d = adv ? 1'b1 : (out_stall_i ? out_valid_q : 1'b0);

  i2cdw_seq #(
    .HOLD_BITS(HOLD_BITS)
  ) u_seq (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .en_i  (adv),
    .req_i (in_q),
    .cfg_i (cfg_q),
    .res_o (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      in_q <= in_req_i;
    end
    if (adv) begin
      out_q <= res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.half_period   <= i2cdw_pkg::HALF_PERIOD_RST;
      cfg_q.slave_address <= i2cdw_pkg::SLAVE_ADDR_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        i2cdw_pkg::CFG_HALF_PERIOD: cfg_q.half_period <= cfg_wdata_i;
        i2cdw_pkg::CFG_SLAVE_ADDR:
          cfg_q.slave_address <= cfg_wdata_i[i2cdw_pkg::AddrW-1:0];
        default: cfg_q <= cfg_q;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_res_o   = out_q;

endmodule

### hw/rtl/i2cdw_seq.sv
// Bus sequencer: pin timing, byte shifting, acknowledge and recovery steps.
`timescale 1ns / 1ps

module i2cdw_seq #(
  parameter int HOLD_BITS = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  i2cdw_pkg::in_t    req_i,
  input  i2cdw_pkg::cfg_t   cfg_i,
  output i2cdw_pkg::out_t   res_o
);

  localparam logic [4:0] ST_IDLE  = 5'd0;
  localparam logic [4:0] ST_S2    = 5'd2;
  localparam logic [4:0] ST_S3    = 5'd3;
  localparam logic [4:0] ST_S4    = 5'd4;
  localparam logic [4:0] ST_BSDA  = 5'd5;
  localparam logic [4:0] ST_BSCLH = 5'd6;
  localparam logic [4:0] ST_BSCLL = 5'd7;
  localparam logic [4:0] ST_ASDA  = 5'd8;
  localparam logic [4:0] ST_ASCLH = 5'd9;
  localparam logic [4:0] ST_ASAMP = 5'd10;
  localparam logic [4:0] ST_P1    = 5'd11;
  localparam logic [4:0] ST_P2    = 5'd12;
  localparam logic [4:0] ST_P3    = 5'd13;
  localparam logic [4:0] ST_FIN   = 5'd14;
  localparam logic [4:0] ST_C2    = 5'd21;
  localparam logic [4:0] ST_CEVAL = 5'd22;
  localparam logic [4:0] ST_RL    = 5'd23;
  localparam logic [4:0] ST_RH    = 5'd24;
  localparam logic [4:0] ST_RSAMP = 5'd25;
  localparam logic [4:0] ST_RP2   = 5'd26;
  localparam logic [4:0] ST_RP3   = 5'd27;
  localparam logic [4:0] ST_F1    = 5'd28;
  localparam logic [4:0] ST_F2    = 5'd29;
  localparam logic [4:0] ST_FEVAL = 5'd30;

  localparam int HpW = i2cdw_pkg::HalfPeriodW;
  localparam int ExtW = (HOLD_BITS > HpW) ? HOLD_BITS : HpW;

  logic [4:0]           step_q, step_d;
  logic [HOLD_BITS-1:0] hold_q, hold_d, hold_nx, ticks;
  logic [7:0]           shift_q, shift_d, latch_q, latch_d;
  logic [3:0]           bit_q, bit_d, bit_nx;
  logic [1:0]           byte_q, byte_d, byte_nx;
  logic [2:0]           ack_q, ack_d;
  logic [3:0]           pulse_q, pulse_d;
  logic [2:0]           op_q, op_d;
  logic                 scl_q, scl_d, sda_q, sda_d;
  logic [1:0]           stuck_q, stuck_d;
  logic                 done, rej, req;
  logic [1:0]           line_st;
  logic [ExtW-1:0]      hp_ext, max_ext;

  // Hold length: zero counts as one, saturate to the counter width.
  always_comb begin
    hp_ext  = ExtW'(cfg_i.half_period);
    max_ext = ExtW'({HOLD_BITS{1'b1}});
    if (cfg_i.half_period == '0) begin
      ticks = HOLD_BITS'(1);
    end else if (hp_ext > max_ext) begin
      ticks = {HOLD_BITS{1'b1}};
    end else begin
      ticks = hp_ext[HOLD_BITS-1:0];
    end
  end

  assign req = (req_i.action != i2cdw_pkg::ACT_TICK) &&
               (req_i.action <= i2cdw_pkg::ACT_CHECK);
  assign line_st = (req_i.scl_in ? 2'b00 : i2cdw_pkg::STUCK_SCL) |
                   (req_i.sda_in ? 2'b00 : i2cdw_pkg::STUCK_SDA);
  assign bit_nx  = bit_q + 4'd1;
  assign byte_nx = byte_q + 2'd1;
  assign hold_nx = (hold_q != '0) ? hold_q - HOLD_BITS'(1) : hold_q;

  always_comb begin
    step_d  = step_q;
    hold_d  = hold_q;
    shift_d = shift_q;
    latch_d = latch_q;
    bit_d   = bit_q;
    byte_d  = byte_q;
    ack_d   = ack_q;
    pulse_d = pulse_q;
    op_d    = op_q;
    scl_d   = scl_q;
    sda_d   = sda_q;
    stuck_d = stuck_q;
    done    = 1'b0;
    rej     = 1'b0;
    if (step_q == ST_IDLE) begin
      if (req) begin
        op_d   = req_i.action;
        sda_d  = 1'b1;
        hold_d = ticks;
        if (req_i.action <= i2cdw_pkg::ACT_PROBE) begin
          latch_d = req_i.payload;
          shift_d = cfg_i.slave_address;
          bit_d   = '0;
          byte_d  = '0;
          ack_d   = '0;
          step_d  = ST_S2;
        end else begin
          stuck_d = '0;
          pulse_d = '0;
          step_d  = ST_C2;
        end
      end
    end else begin
      rej    = req;
      hold_d = hold_nx;
      if (hold_nx == '0) begin
        unique case (step_q)
          ST_S2: begin
            scl_d = 1'b1; hold_d = ticks; step_d = ST_S3;
          end
          ST_S3: begin
            sda_d = 1'b0; hold_d = ticks; step_d = ST_S4;
          end
          ST_S4: begin
            scl_d = 1'b0; hold_d = ticks; step_d = ST_BSDA;
          end
          ST_BSDA: begin
            sda_d = shift_q[~bit_q[2:0]]; hold_d = ticks; step_d = ST_BSCLH;
          end
          ST_BSCLH: begin
            scl_d = 1'b1; hold_d = ticks; step_d = ST_BSCLL;
          end
          ST_BSCLL: begin
            scl_d  = 1'b0;
            hold_d = ticks;
            bit_d  = bit_nx;
            step_d = (bit_nx < 4'd8) ? ST_BSDA : ST_ASDA;
          end
          ST_ASDA: begin
            sda_d = 1'b1; hold_d = ticks; step_d = ST_ASCLH;
          end
          ST_ASCLH: begin
            scl_d = 1'b1; hold_d = ticks; step_d = ST_ASAMP;
          end
          ST_ASAMP: begin
            if (!req_i.sda_in) begin
              ack_d = ack_q | 3'(4'b0001 << byte_q);
            end
            scl_d  = 1'b0;
            hold_d = ticks;
            byte_d = byte_nx;
            if ((op_q != i2cdw_pkg::ACT_PROBE) && (byte_nx != 2'd3)) begin
              if (byte_nx == 2'd1) begin
                shift_d = (op_q == i2cdw_pkg::ACT_DATA) ? i2cdw_pkg::CTRL_DATA
                                                        : i2cdw_pkg::CTRL_CMD;
              end else begin
                shift_d = latch_q;
              end
              bit_d  = '0;
              step_d = ST_BSDA;
            end else begin
              step_d = ST_P1;
            end
          end
          ST_P1: begin
            sda_d = 1'b0; hold_d = ticks; step_d = ST_P2;
          end
          ST_P2: begin
            scl_d = 1'b1; hold_d = ticks; step_d = ST_P3;
          end
          ST_P3: begin
            sda_d = 1'b1; hold_d = ticks; step_d = ST_FIN;
          end
          ST_FIN: begin
            step_d = ST_IDLE; done = 1'b1;
          end
          ST_C2: begin
            scl_d = 1'b1; hold_d = ticks; step_d = ST_CEVAL;
          end
          ST_CEVAL: begin
            if (op_q != i2cdw_pkg::ACT_RECOVER) begin
              stuck_d = line_st; step_d = ST_IDLE; done = 1'b1;
            end else if (req_i.sda_in) begin
              stuck_d = '0; step_d = ST_IDLE; done = 1'b1;
            end else begin
              sda_d = 1'b1; hold_d = ticks; pulse_d = '0; step_d = ST_RL;
            end
          end
          ST_RL: begin
            scl_d = 1'b0; hold_d = ticks; step_d = ST_RH;
          end
          ST_RH: begin
            scl_d   = 1'b1;
            hold_d  = ticks;
            pulse_d = pulse_q + 4'd1;
            step_d  = ST_RSAMP;
          end
          ST_RSAMP: begin
            hold_d = ticks;
            if (req_i.sda_in || (pulse_q >= i2cdw_pkg::RECOVER_PULSES)) begin
              sda_d = 1'b0; step_d = ST_RP2;
            end else begin
              scl_d = 1'b0; step_d = ST_RH;
            end
          end
          ST_RP2: begin
            scl_d = 1'b1; hold_d = ticks; step_d = ST_RP3;
          end
          ST_RP3: begin
            sda_d = 1'b1; hold_d = ticks; step_d = ST_F1;
          end
          ST_F1: begin
            sda_d = 1'b1; hold_d = ticks; step_d = ST_F2;
          end
          ST_F2: begin
            scl_d = 1'b1; hold_d = ticks; step_d = ST_FEVAL;
          end
          ST_FEVAL: begin
            stuck_d = line_st; step_d = ST_IDLE; done = 1'b1;
          end
          default: begin
            step_d = ST_IDLE;
          end
        endcase
      end
    end
  end

  always_comb begin
    res_o.scl_out    = scl_d;
    res_o.sda_out    = sda_d;
    res_o.busy_res   = (step_d != ST_IDLE);
    res_o.done_res   = done;
    res_o.ack_bits   = ack_d;
    res_o.bus_status = stuck_d;
    res_o.rejected   = rej;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q  <= ST_IDLE;
      hold_q  <= '0;
      shift_q <= '0;
      latch_q <= '0;
      bit_q   <= '0;
      byte_q  <= '0;
      ack_q   <= '0;
      pulse_q <= '0;
      op_q    <= '0;
      scl_q   <= 1'b1;
      sda_q   <= 1'b1;
      stuck_q <= '0;
    end else if (en_i) begin
      step_q  <= step_d;
      hold_q  <= hold_d;
      shift_q <= shift_d;
      latch_q <= latch_d;
      bit_q   <= bit_d;
      byte_q  <= byte_d;
      ack_q   <= ack_d;
      pulse_q <= pulse_d;
      op_q    <= op_d;
      scl_q   <= scl_d;
      sda_q   <= sda_d;
      stuck_q <= stuck_d;
    end
  end

endmodule

### hw/rtl/i2cdw_checker.sv
// Port-level checker for the display write master, bound to the top level.
`timescale 1ns / 1ps
`include "i2c_display_write_master_core_macros.svh"

module i2cdw_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           in_stall_o,
  input logic                           out_valid_o,
  input logic                           out_stall_i,
  input i2cdw_pkg::out_t                out_res_o
);

  `I2CDW_ASSERT_CLK(a_out_hold, out_valid_o && out_stall_i |=> out_valid_o, "result dropped")
  `I2CDW_ASSERT_CLK(a_out_stable,
                    out_valid_o && out_stall_i |=> $stable(out_res_o), "result changed")
  `I2CDW_ASSERT_NEVER(a_done_busy,
                      out_valid_o && out_res_o.done_res && out_res_o.busy_res, "done while busy")
  `I2CDW_ASSERT_NEVER(a_stall_src,
                      in_stall_o && !(out_valid_o && out_stall_i), "stall without back pressure")

endmodule

bind i2c_display_write_master_core i2cdw_checker u_i2cdw_checker (.*);

### test/testbench.sv
// Self-checking testbench of the display write master: directed rows, then random bus ticks.
`timescale 1ns / 1ps
module testbench;

  localparam int HoldBits    = 16;
  localparam int RandItems   = 1050;
  localparam int MaxShown    = 10;
  localparam int CycleLimit  = 2000000;
  localparam int LongHoldOff = 400;
  localparam int InW         = $bits(i2cdw_pkg::in_t);

  typedef enum logic [6:0] {
    SQ_IDLE        = 7'd0,
    SQ_ST_SDA      = 7'd1,
    SQ_ST_SCL      = 7'd2,
    SQ_ST_LOW      = 7'd3,
    SQ_ST_CLK      = 7'd4,
    SQ_BIT_SDA     = 7'd5,
    SQ_BIT_SCLH    = 7'd6,
    SQ_BIT_SCLL    = 7'd7,
    SQ_ACK_SDA     = 7'd8,
    SQ_ACK_SCLH    = 7'd9,
    SQ_ACK_SAMP    = 7'd10,
    SQ_SP_SDA      = 7'd11,
    SQ_SP_SCL      = 7'd12,
    SQ_SP_REL      = 7'd13,
    SQ_FIN         = 7'd14,
    SQ_CK_SDA      = 7'd20,
    SQ_CK_SCL      = 7'd21,
    SQ_CK_EVAL     = 7'd22,
    SQ_RC_LOW      = 7'd23,
    SQ_RC_HIGH     = 7'd24,
    SQ_RC_SAMP     = 7'd25,
    SQ_RC_STOP_SCL = 7'd26,
    SQ_RC_STOP_SDA = 7'd27,
    SQ_FC_SDA      = 7'd28,
    SQ_FC_SCL      = 7'd29,
    SQ_FC_EVAL     = 7'd30
  } seq_e;

  // line levels driven while a sequence runs to its end
  typedef enum logic [1:0] {FILL_NONE, FILL_LOW, FILL_HIGH, FILL_RAND} fill_e;

  typedef struct packed {
    logic                               is_cfg;
    logic [i2cdw_pkg::CfgIdxW-1:0]      idx;
    logic [i2cdw_pkg::CfgDataW-1:0]     val;
    i2cdw_pkg::in_t                     req;
    logic                               typed;
    i2cdw_pkg::out_t                    res;
    fill_e                              fill;
  } row_t;

  localparam i2cdw_pkg::out_t IdleRes     = {1'b1, 1'b1, 1'b0, 1'b0, 3'd0, 2'd0, 1'b0};
  localparam i2cdw_pkg::out_t CheckRes    = {1'b1, 1'b1, 1'b1, 1'b0, 3'd0, 2'd0, 1'b0};
  localparam i2cdw_pkg::out_t CheckRejRes = {1'b1, 1'b1, 1'b1, 1'b0, 3'd0, 2'd0, 1'b1};

  logic                           clk_i       = 1'b0;
  logic                           rst_ni      = 1'b0;
  logic                           in_valid    = 1'b0;
  logic                           in_stall_o;
  i2cdw_pkg::in_t                 in_req      = '0;
  logic                           out_valid_o;
  logic                           out_stall_i = 1'b0;
  i2cdw_pkg::out_t                out_res_o;
  logic                           cfg_we      = 1'b0;
  logic [i2cdw_pkg::CfgIdxW-1:0]  cfg_idx     = '0;
  logic [i2cdw_pkg::CfgDataW-1:0] cfg_wdata   = '0;

  i2c_display_write_master_core #(
    .HOLD_BITS(HoldBits)
  ) u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall_o),
    .in_req_i   (in_req),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_res_o  (out_res_o),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_wdata_i(cfg_wdata)
  );

  always #5 clk_i = ~clk_i;

  // bus master prediction state
  logic [15:0] cfg_half   = i2cdw_pkg::HALF_PERIOD_RST;
  logic [7:0]  cfg_addr   = i2cdw_pkg::SLAVE_ADDR_RST;
  seq_e        p_step     = SQ_IDLE;
  logic [31:0] p_hold     = '0;
  logic [7:0]  p_shift    = '0;
  logic [3:0]  p_bit      = '0;
  logic [1:0]  p_byte     = '0;
  logic [2:0]  p_acks     = '0;
  logic [3:0]  p_pulses   = '0;
  logic [2:0]  p_op       = '0;
  logic        p_scl      = 1'b1;
  logic        p_sda      = 1'b1;
  logic [1:0]  p_stuck    = '0;
  logic [7:0]  p_payload  = '0;

  i2cdw_pkg::out_t tick_results_q [$];
  row_t plan_q [$];
  int   mismatches = 0;
  int   results_seen = 0;
  int   items_sent = 0;
  int   burst_left = 0;
  int   cycles = 0;
  logic valid_up = 1'b0;

  function automatic logic [31:0] hold_len();
    logic [31:0] h;
    h = (cfg_half == 16'd0) ? 32'd1 : 32'(cfg_half);
    if (h > (32'd1 << HoldBits) - 32'd1) h = (32'd1 << HoldBits) - 32'd1;
    return h;
  endfunction

  function automatic void drive_scl(logic v);
    p_scl  = v;
    p_hold = hold_len();
  endfunction

  function automatic void drive_sda(logic v);
    p_sda  = v;
    p_hold = hold_len();
  endfunction

  function automatic logic [1:0] line_flags(logic sda, logic scl);
    logic [1:0] f;
    f = '0;
    if (!scl) f = f | i2cdw_pkg::STUCK_SCL;
    if (!sda) f = f | i2cdw_pkg::STUCK_SDA;
    return f;
  endfunction

  // one pin action of the sequencer; returns 1 when the sequence ends
  function automatic logic sequencer_step(logic sda, logic scl);
    logic fin;
    fin = 1'b0;
    case (p_step)
      SQ_ST_SDA: begin drive_sda(1'b1); p_step = SQ_ST_SCL; end
      SQ_ST_SCL: begin drive_scl(1'b1); p_step = SQ_ST_LOW; end
      SQ_ST_LOW: begin drive_sda(1'b0); p_step = SQ_ST_CLK; end
      SQ_ST_CLK: begin drive_scl(1'b0); p_step = SQ_BIT_SDA; end
      SQ_BIT_SDA: begin
        drive_sda(p_shift[~p_bit[2:0]]);
        p_step = SQ_BIT_SCLH;
      end
      SQ_BIT_SCLH: begin drive_scl(1'b1); p_step = SQ_BIT_SCLL; end
      SQ_BIT_SCLL: begin
        drive_scl(1'b0);
        p_bit  = p_bit + 4'd1;
        p_step = (p_bit < 4'd8) ? SQ_BIT_SDA : SQ_ACK_SDA;
      end
      SQ_ACK_SDA: begin drive_sda(1'b1); p_step = SQ_ACK_SCLH; end
      SQ_ACK_SCLH: begin drive_scl(1'b1); p_step = SQ_ACK_SAMP; end
      SQ_ACK_SAMP: begin
        if (!sda && p_byte != 2'd3) p_acks[p_byte] = 1'b1;
        drive_scl(1'b0);
        p_byte = p_byte + 2'd1;
        if (p_op != i2cdw_pkg::ACT_PROBE && p_byte < 2'd3) begin
          if (p_byte == 2'd1) begin
            p_shift = (p_op == i2cdw_pkg::ACT_DATA) ? i2cdw_pkg::CTRL_DATA
                                                    : i2cdw_pkg::CTRL_CMD;
          end else begin
            p_shift = p_payload;
          end
          p_bit  = '0;
          p_step = SQ_BIT_SDA;
        end else begin
          p_step = SQ_SP_SDA;
        end
      end
      SQ_SP_SDA: begin drive_sda(1'b0); p_step = SQ_SP_SCL; end
      SQ_SP_SCL: begin drive_scl(1'b1); p_step = SQ_SP_REL; end
      SQ_SP_REL: begin drive_sda(1'b1); p_step = SQ_FIN; end
      SQ_FIN: begin p_step = SQ_IDLE; fin = 1'b1; end
      SQ_CK_SDA: begin drive_sda(1'b1); p_step = SQ_CK_SCL; end
      SQ_CK_SCL: begin drive_scl(1'b1); p_step = SQ_CK_EVAL; end
      SQ_CK_EVAL: begin
        if (p_op != i2cdw_pkg::ACT_RECOVER) begin
          p_stuck = line_flags(sda, scl);
          p_step  = SQ_IDLE;
          fin     = 1'b1;
        end else if (sda) begin
          p_stuck = '0;
          p_step  = SQ_IDLE;
          fin     = 1'b1;
        end else begin
          drive_sda(1'b1);
          p_pulses = '0;
          p_step   = SQ_RC_LOW;
        end
      end
      SQ_RC_LOW: begin drive_scl(1'b0); p_step = SQ_RC_HIGH; end
      SQ_RC_HIGH: begin
        drive_scl(1'b1);
        p_pulses = p_pulses + 4'd1;
        p_step   = SQ_RC_SAMP;
      end
      SQ_RC_SAMP: begin
        if (sda || p_pulses >= i2cdw_pkg::RECOVER_PULSES) begin
          drive_sda(1'b0);
          p_step = SQ_RC_STOP_SCL;
        end else begin
          drive_scl(1'b0);
          p_step = SQ_RC_HIGH;
        end
      end
      SQ_RC_STOP_SCL: begin drive_scl(1'b1); p_step = SQ_RC_STOP_SDA; end
      SQ_RC_STOP_SDA: begin drive_sda(1'b1); p_step = SQ_FC_SDA; end
      SQ_FC_SDA: begin drive_sda(1'b1); p_step = SQ_FC_SCL; end
      SQ_FC_SCL: begin drive_scl(1'b1); p_step = SQ_FC_EVAL; end
      SQ_FC_EVAL: begin
        p_stuck = line_flags(sda, scl);
        p_step  = SQ_IDLE;
        fin     = 1'b1;
      end
      default: p_step = SQ_IDLE;
    endcase
    return fin;
  endfunction

  function automatic i2cdw_pkg::out_t predict_tick(i2cdw_pkg::in_t r);
    i2cdw_pkg::out_t o;
    logic fin;
    logic rej;
    logic is_req;
    fin    = 1'b0;
    rej    = 1'b0;
    is_req = (r.action >= i2cdw_pkg::ACT_CMD && r.action <= i2cdw_pkg::ACT_CHECK);
    if (p_step == SQ_IDLE) begin
      if (is_req) begin
        p_op = r.action;
        if (r.action <= i2cdw_pkg::ACT_PROBE) begin
          p_payload = r.payload;
          p_shift   = cfg_addr;
          p_bit     = '0;
          p_byte    = '0;
          p_acks    = '0;
          p_step    = SQ_ST_SDA;
        end else begin
          p_stuck  = '0;
          p_pulses = '0;
          p_step   = SQ_CK_SDA;
        end
        fin = sequencer_step(r.sda_in, r.scl_in);
      end
    end else begin
      rej = is_req;
      if (p_hold != 0) p_hold = p_hold - 32'd1;
      if (p_hold == 0) fin = sequencer_step(r.sda_in, r.scl_in);
    end
    o.scl_out    = p_scl;
    o.sda_out    = p_sda;
    o.busy_res   = (p_step != SQ_IDLE);
    o.done_res   = fin;
    o.ack_bits   = p_acks;
    o.bus_status = p_stuck;
    o.rejected   = rej;
    return o;
  endfunction

  task automatic drop_valid();
    if (valid_up) begin
      in_valid <= 1'b0;
      valid_up = 1'b0;
    end
  endtask

  task automatic offer(i2cdw_pkg::in_t r, logic typed, i2cdw_pkg::out_t res);
    i2cdw_pkg::out_t want;
    in_req   <= r;
    in_valid <= 1'b1;
    valid_up = 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    want = predict_tick(r);
    tick_results_q.push_back(typed ? res : want);
    items_sent++;
    if (burst_left != 0) begin
      burst_left--;
    end else begin
      drop_valid();
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(60, 200) : $urandom_range(0, 12);
    end
  endtask

  // keep ticking until the running sequence is over, unless the fill is FILL_NONE
  task automatic finish_sequence(fill_e how);
    i2cdw_pkg::in_t r;
    if (how == FILL_NONE) return;
    while (p_step != SQ_IDLE) begin
      r = InW'($urandom);
      r.action = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(1, 7))
                                             : i2cdw_pkg::ACT_TICK;
      case (how)
        FILL_LOW: begin r.sda_in = 1'b0; r.scl_in = 1'b0; end
        FILL_HIGH: begin r.sda_in = 1'b1; r.scl_in = 1'b1; end
        default: r.sda_in = ($urandom_range(0, 3) == 0);
      endcase
      offer(r, 1'b0, '0);
    end
  endtask

  task automatic wait_drained();
    while (tick_results_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [i2cdw_pkg::CfgIdxW-1:0] idx,
                           logic [i2cdw_pkg::CfgDataW-1:0] val);
    finish_sequence(FILL_RAND);
    drop_valid();
    wait_drained();
    repeat (4) @(posedge clk_i);
    cfg_idx   <= idx;
    cfg_wdata <= val;
    cfg_we    <= 1'b1;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    if (idx == i2cdw_pkg::CFG_HALF_PERIOD) cfg_half = val;
    else cfg_addr = val[7:0];
  endtask

  function automatic void add_req(logic [2:0] act, logic [7:0] pay, logic sda, logic scl,
                                  logic typed, i2cdw_pkg::out_t res, fill_e fill);
    row_t w;
    w        = '0;
    w.req    = {act, pay, sda, scl};
    w.typed  = typed;
    w.res    = res;
    w.fill   = fill;
    plan_q.push_back(w);
  endfunction

  function automatic void add_cfg(logic [i2cdw_pkg::CfgIdxW-1:0] idx,
                                  logic [i2cdw_pkg::CfgDataW-1:0] val);
    row_t w;
    w        = '0;
    w.is_cfg = 1'b1;
    w.idx    = idx;
    w.val    = val;
    plan_q.push_back(w);
  endfunction

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    i2cdw_pkg::out_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      results_seen++;
      if (tick_results_q.size() == 0) begin
        mismatches++;
        if (mismatches <= MaxShown)
          $display("result %0d with no request pending: %h", results_seen, out_res_o);
      end else begin
        want = tick_results_q.pop_front();
        if (out_res_o !== want) begin
          mismatches++;
          if (mismatches <= MaxShown)
            $display({"result %0d: want scl %b sda %b busy %b done %b ack %b bus %b rej %b,",
                      " got scl %b sda %b busy %b done %b ack %b bus %b rej %b"},
                     results_seen, want.scl_out, want.sda_out, want.busy_res,
                     want.done_res, want.ack_bits, want.bus_status, want.rejected,
                     out_res_o.scl_out, out_res_o.sda_out, out_res_o.busy_res,
                     out_res_o.done_res, out_res_o.ack_bits, out_res_o.bus_status,
                     out_res_o.rejected);
        end
      end
    end
  end

  // result side: stall patterns, one long hold-off so the input backs up
  initial begin
    int mode;
    int span;
    int n;
    @(posedge rst_ni);
    for (n = 0; ; n++) begin
      if (n == 8) begin
        while (!in_valid) @(posedge clk_i);
        out_stall_i <= 1'b1;
        repeat (LongHoldOff) @(posedge clk_i);
      end else begin
        mode = $urandom_range(0, 3);
        span = $urandom_range(20, 120);
        repeat (span) begin
          case (mode)
            0: out_stall_i <= 1'b0;
            1: out_stall_i <= ($urandom_range(0, 3) == 0);
            2: out_stall_i <= ($urandom_range(0, 3) != 0);
            default: out_stall_i <= ~out_stall_i;
          endcase
          @(posedge clk_i);
        end
      end
    end
  end

  initial begin
    i2cdw_pkg::in_t r;
    int start;
    logic [15:0] hp;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings: idle ticks, unknown actions, a busy-time request
    add_req(i2cdw_pkg::ACT_TICK, 8'h00, 1'b1, 1'b1, 1'b1, IdleRes, FILL_NONE);
    add_req(3'd6, 8'hFF, 1'b0, 1'b0, 1'b1, IdleRes, FILL_NONE);
    add_req(3'd7, 8'h00, 1'b1, 1'b0, 1'b1, IdleRes, FILL_NONE);
    add_req(i2cdw_pkg::ACT_CHECK, 8'h00, 1'b1, 1'b1, 1'b1, CheckRes, FILL_NONE);
    add_req(i2cdw_pkg::ACT_CMD, 8'hA5, 1'b0, 1'b1, 1'b1, CheckRejRes, FILL_LOW);
    add_req(i2cdw_pkg::ACT_CHECK, 8'h00, 1'b0, 1'b0, 1'b0, '0, FILL_HIGH);
    // zero half period behaves as one tick
    add_cfg(i2cdw_pkg::CFG_HALF_PERIOD, 16'd0);
    add_req(i2cdw_pkg::ACT_CMD, 8'h00, 1'b1, 1'b1, 1'b0, '0, FILL_LOW);
    add_cfg(i2cdw_pkg::CFG_SLAVE_ADDR, 16'h00FF);
    add_req(i2cdw_pkg::ACT_DATA, 8'hFF, 1'b0, 1'b0, 1'b0, '0, FILL_HIGH);
    add_cfg(i2cdw_pkg::CFG_HALF_PERIOD, 16'd1);
    add_cfg(i2cdw_pkg::CFG_SLAVE_ADDR, 16'h0000);
    add_req(i2cdw_pkg::ACT_PROBE, 8'h5A, 1'b1, 1'b1, 1'b0, '0, FILL_RAND);
    add_req(i2cdw_pkg::ACT_PROBE, 8'h00, 1'b0, 1'b0, 1'b0, '0, FILL_LOW);
    add_req(i2cdw_pkg::ACT_RECOVER, 8'h00, 1'b1, 1'b1, 1'b0, '0, FILL_HIGH);
    add_req(i2cdw_pkg::ACT_RECOVER, 8'h00, 1'b0, 1'b0, 1'b0, '0, FILL_LOW);
    add_req(i2cdw_pkg::ACT_RECOVER, 8'h3C, 1'b0, 1'b1, 1'b0, '0, FILL_RAND);
    add_req(i2cdw_pkg::ACT_CHECK, 8'h00, 1'b1, 1'b0, 1'b0, '0, FILL_RAND);
    add_req(i2cdw_pkg::ACT_DATA, 8'h81, 1'b1, 1'b1, 1'b0, '0, FILL_RAND);
    add_req(i2cdw_pkg::ACT_CMD, 8'h7E, 1'b1, 1'b1, 1'b0, '0, FILL_RAND);
    // long hold: a full check at a wide half period
    add_cfg(i2cdw_pkg::CFG_HALF_PERIOD, 16'd100);
    add_req(i2cdw_pkg::ACT_CHECK, 8'h00, 1'b0, 1'b1, 1'b0, '0, FILL_RAND);
    add_cfg(i2cdw_pkg::CFG_HALF_PERIOD, 16'd2);
    add_cfg(i2cdw_pkg::CFG_SLAVE_ADDR, 16'h003C);

    foreach (plan_q[i]) begin
      if (plan_q[i].is_cfg) begin
        write_reg(plan_q[i].idx, plan_q[i].val);
      end else begin
        offer(plan_q[i].req, plan_q[i].typed, plan_q[i].res);
        finish_sequence(plan_q[i].fill);
      end
    end

    start = items_sent;
    while (items_sent - start < RandItems) begin
      if ($urandom_range(0, 6) == 0) begin
        case ($urandom_range(0, 7))
          0: hp = 16'd0;
          1, 2, 3: hp = 16'd1;
          4: hp = 16'd2;
          5: hp = 16'd3;
          default: hp = 16'($urandom_range(4, 9));
        endcase
        write_reg(i2cdw_pkg::CFG_HALF_PERIOD, hp);
        write_reg(i2cdw_pkg::CFG_SLAVE_ADDR, 16'($urandom_range(0, 255)));
      end
      if ($urandom_range(0, 7) == 0) begin
        repeat ($urandom_range(1, 6)) begin
          r = InW'($urandom);
          r.action = ($urandom_range(0, 1) == 0) ? i2cdw_pkg::ACT_TICK
                                                 : 3'($urandom_range(6, 7));
          offer(r, 1'b0, '0);
        end
      end else begin
        r = InW'($urandom);
        r.action = 3'($urandom_range(i2cdw_pkg::ACT_CMD, i2cdw_pkg::ACT_CHECK));
        offer(r, 1'b0, '0);
        case ($urandom_range(0, 7))
          0: finish_sequence(FILL_LOW);
          1: finish_sequence(FILL_HIGH);
          default: finish_sequence(FILL_RAND);
        endcase
      end
    end

    drop_valid();
    wait_drained();
    repeat (10) @(posedge clk_i);
    if (mismatches == 0 && tick_results_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

### i2c_display_write_master_core.f
+incdir+hw/rtl
hw/rtl/i2cdw_pkg.sv
hw/rtl/i2cdw_seq.sv
hw/rtl/i2c_display_write_master_core.sv
hw/rtl/i2cdw_checker.sv
test/testbench.sv
